>>> hdl/assert_macros.svh
// assertion macros shared by the piece table engine modules
// expects signals named clk and rst_n in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pte_pkg.sv
// shared types and codes for the piece table engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pte_pkg;

  // command codes
  localparam logic [2:0] CMD_CLEAR     = 3'd0;
  localparam logic [2:0] CMD_LOAD_ADD  = 3'd1;
  localparam logic [2:0] CMD_LOAD_ORIG = 3'd2;
  localparam logic [2:0] CMD_INSERT    = 3'd3;
  localparam logic [2:0] CMD_ERASE     = 3'd4;
  localparam logic [2:0] CMD_READ      = 3'd5;

  // status codes
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_NOP  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_OVF  = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] position;
    logic [31:0] count;
  } pte_in_t;

  typedef struct packed {
    logic        seg_source;
    logic [31:0] seg_start;
    logic [31:0] seg_length;
    logic        last;
    logic [1:0]  status;
    logic [31:0] doc_size;
    logic [6:0]  used_pieces;
  } pte_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FETCH, S_PA, S_PB, S_PC, S_TAIL, S_FLUSH, S_COMMIT, S_DONE
  } pte_state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic early;
    logic init;
    logic push_a;
    logic push_b;
    logic push_c;
    logic advance;
    logic push_tail;
    logic flush;
    logic commit;
    logic emit_done;
  } pte_ctl_t;

  // datapath status to the controller
  typedef struct packed {
    logic simple;
    logic early_stop;
    logic empty;
    logic i_last;
    logic seg_last;
    logic is_read;
  } pte_sts_t;

endpackage

`default_nettype wire

>>> hdl/pte_ctrl.sv
// command sequencer for the piece table engine
// depends on pte_pkg
`timescale 1ns / 1ps
`default_nettype none

module pte_ctrl import pte_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire pte_sts_t sts,
  output pte_ctl_t      ctl
);

  pte_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.simple) begin
          ctl.load  = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.early_stop) begin
          ctl.early = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ctl.init  = 1'b1;
          state_nxt = sts.empty ? S_TAIL : S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_PA;
      S_PA: begin
        ctl.push_a = 1'b1;
        state_nxt  = (sts.is_read && sts.seg_last) ? S_IDLE : S_PB;
      end
      S_PB: begin
        ctl.push_b = 1'b1;
        state_nxt  = S_PC;
      end
      S_PC: begin
        ctl.push_c  = 1'b1;
        ctl.advance = 1'b1;
        state_nxt   = sts.i_last ? S_TAIL : S_FETCH;
      end
      S_TAIL: begin
        ctl.push_tail = 1'b1;
        state_nxt     = S_FLUSH;
      end
      S_FLUSH: begin
        ctl.flush = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        ctl.emit_done = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/pte_datapath.sv
// piece table storage, work table builder and result register
// depends on pte_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pte_datapath import pte_pkg::*; #(
  parameter int MAX_PIECES  = 64,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire pte_in_t  in_data,
  input  wire pte_ctl_t ctl,
  output pte_sts_t      sts,
  output logic          out_valid,
  output pte_out_t      out_data
);

  localparam int OB = OFFSET_BITS;
  localparam int IW = $clog2(MAX_PIECES);
  localparam int CW = $clog2(MAX_PIECES + 2);
  localparam int EW = 1 + 2 * OB;
  localparam int DEPTH = 2 ** (IW + 1);
  localparam logic [OB-1:0] MASK = '1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_PIECES);

  // two banks: current table and work table
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_r;
  logic          wr_en;
  logic [IW:0]   wr_addr;
  logic [EW-1:0] wr_data;

  logic [2:0]    cmd_r;
  logic [OB-1:0] pos_r, cnt_r, stop_r, cursor_r;
  logic [OB-1:0] fill_r, size_r;
  logic [CW-1:0] count_r, i_r, wn_r;
  logic          bank_r, placed_r;
  logic          tail_src_r;
  logic [OB-1:0] tail_start_r, tail_len_r;
  logic [1:0]    status_r;
  logic          out_valid_r;
  pte_out_t      out_r;

  logic [OB-1:0] in_pos, in_cnt;
  logic          e_src;
  logic [OB-1:0] e_start, e_len, e_end, local_off;
  logic          ins_hit, ovl;
  logic          is_ins, is_era;
  logic          p_v, p_src;
  logic [OB-1:0] p_start, p_len;
  logic          merge;
  logic [CW-1:0] wn_m1;
  logic          tail_wr_ok;
  logic [1:0]    chk_status;
  logic [OB-1:0] ls, le;

  assign in_pos  = OB'(in_data.position);
  assign in_cnt  = OB'(in_data.count);
  assign e_src   = rdata_r[EW-1];
  assign e_start = rdata_r[2*OB-1:OB];
  assign e_len   = rdata_r[OB-1:0];
  assign e_end   = cursor_r + e_len;
  assign local_off = pos_r - cursor_r;
  assign is_ins  = (cmd_r == CMD_INSERT);
  assign is_era  = (cmd_r == CMD_ERASE);
  assign ins_hit = !placed_r && (pos_r <= e_end);
  assign ovl     = !((e_end <= pos_r) || (cursor_r >= stop_r));
  assign wn_m1   = wn_r - CW'(1);
  assign tail_wr_ok = (wn_r != '0) && (wn_r <= MAXC);
  assign merge   = (wn_r != '0) && (tail_src_r == p_src) &&
                   ((tail_start_r + tail_len_r) == p_start);

  // read span bounds relative to the piece
  assign ls = ((pos_r > cursor_r) ? pos_r : cursor_r) - cursor_r;
  assign le = ((stop_r < e_end) ? stop_r : e_end) - cursor_r;

  // early checks on a captured command
  always_comb begin
    chk_status = STAT_DONE;
    case (cmd_r)
      CMD_INSERT: begin
        if (cnt_r == '0) begin
          chk_status = STAT_NOP;
        end else if ((cnt_r > MASK - fill_r) || (cnt_r > MASK - size_r)) begin
          chk_status = STAT_OVF;
        end
      end
      CMD_ERASE, CMD_READ: begin
        if ((cnt_r == '0) || (pos_r >= size_r)) begin
          chk_status = STAT_NOP;
        end
      end
      CMD_CLEAR, CMD_LOAD_ADD, CMD_LOAD_ORIG: chk_status = STAT_DONE;
      default: chk_status = STAT_NOP;
    endcase
  end

  always_comb begin
    sts.simple     = (cmd_r == CMD_CLEAR) || (cmd_r == CMD_LOAD_ADD) ||
                     (cmd_r == CMD_LOAD_ORIG);
    sts.early_stop = (chk_status != STAT_DONE);
    sts.empty      = (count_r == '0);
    sts.i_last     = ((i_r + CW'(1)) == count_r);
    sts.seg_last   = ovl && (e_end >= stop_r);
    sts.is_read    = (cmd_r == CMD_READ);
  end

  // piece pushed to the work table this cycle
  always_comb begin
    p_v     = 1'b0;
    p_src   = e_src;
    p_start = e_start;
    p_len   = e_len;
    if (ctl.push_a) begin
      if (is_ins) begin
        p_v   = ins_hit ? (local_off != '0) : 1'b1;
        p_len = ins_hit ? local_off : e_len;
      end else if (is_era) begin
        p_v   = ovl ? (pos_r > cursor_r) : 1'b1;
        p_len = ovl ? (pos_r - cursor_r) : e_len;
      end
    end else if (ctl.push_b) begin
      p_v     = is_ins && ins_hit;
      p_src   = 1'b1;
      p_start = fill_r;
      p_len   = cnt_r;
    end else if (ctl.push_c) begin
      if (is_ins) begin
        p_v     = ins_hit && (local_off < e_len);
        p_start = e_start + local_off;
        p_len   = e_len - local_off;
      end else if (is_era) begin
        p_v     = ovl && (stop_r < e_end);
        p_start = e_start + (stop_r - cursor_r);
        p_len   = e_end - stop_r;
      end
    end else if (ctl.push_tail) begin
      p_v     = is_ins && !placed_r;
      p_src   = 1'b1;
      p_start = fill_r;
      p_len   = cnt_r;
    end
  end

  // memory write port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {~bank_r, wn_m1[IW-1:0]};
    wr_data = {tail_src_r, tail_start_r, tail_len_r};
    if (ctl.load) begin
      wr_en   = 1'b1;
      wr_addr = {bank_r, {IW{1'b0}}};
      wr_data = {(cmd_r == CMD_LOAD_ADD), {OB{1'b0}}, cnt_r};
    end else if (ctl.flush || (p_v && !merge)) begin
      wr_en = tail_wr_ok;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[{bank_r, i_r[IW-1:0]}];
  end

  // command registers and walk state
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_data.cmd;
      pos_r <= in_pos;
      cnt_r <= in_cnt;
    end
    if (ctl.init) begin
      if (is_ins && (pos_r > size_r)) begin
        pos_r <= size_r;
      end
      stop_r   <= (cnt_r > size_r - pos_r) ? size_r : pos_r + cnt_r;
      cursor_r <= '0;
    end
    if (ctl.advance) begin
      cursor_r <= e_end;
    end
    if (p_v) begin
      if (merge) begin
        tail_len_r <= tail_len_r + p_len;
      end else begin
        tail_src_r   <= p_src;
        tail_start_r <= p_start;
        tail_len_r   <= p_len;
      end
    end
  end

  // control and table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      fill_r   <= '0;
      size_r   <= '0;
      bank_r   <= 1'b0;
      i_r      <= '0;
      wn_r     <= '0;
      placed_r <= 1'b0;
      status_r <= STAT_DONE;
    end else begin
      if (ctl.load) begin
        status_r <= STAT_DONE;
        if ((cnt_r != '0) && (cmd_r != CMD_CLEAR)) begin
          count_r <= CW'(1);
          size_r  <= cnt_r;
        end else begin
          count_r <= '0;
          size_r  <= '0;
        end
        fill_r <= (cmd_r == CMD_LOAD_ADD) ? cnt_r : '0;
      end
      if (ctl.early) begin
        status_r <= chk_status;
      end
      if (ctl.init) begin
        i_r      <= '0;
        wn_r     <= '0;
        placed_r <= 1'b0;
      end
      if (ctl.advance) begin
        i_r <= i_r + CW'(1);
        if (is_ins && ins_hit) begin
          placed_r <= 1'b1;
        end
      end
      if (p_v && !merge && (wn_r <= MAXC)) begin
        wn_r <= wn_r + CW'(1);
      end
      if (ctl.commit) begin
        if (wn_r <= MAXC) begin
          status_r <= STAT_DONE;
          bank_r   <= ~bank_r;
          count_r  <= wn_r;
          if (is_ins) begin
            size_r <= size_r + cnt_r;
            fill_r <= fill_r + cnt_r;
          end else begin
            size_r <= size_r - (stop_r - pos_r);
          end
        end else begin
          status_r <= STAT_FULL;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit_done || (ctl.push_a && sts.is_read && ovl);
    end
  end

  always_ff @(posedge clk) begin
    out_r.doc_size    <= 32'(size_r);
    out_r.used_pieces <= 7'(count_r);
    if (ctl.emit_done) begin
      out_r.seg_source <= 1'b0;
      out_r.seg_start  <= '0;
      out_r.seg_length <= '0;
      out_r.last       <= 1'b1;
      out_r.status     <= status_r;
    end else begin
      out_r.seg_source <= e_src;
      out_r.seg_start  <= 32'(e_start + ls);
      out_r.seg_length <= 32'(le - ls);
      out_r.last       <= sts.seg_last;
      out_r.status     <= STAT_DONE;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PTE_ASSERT_IMP(a_wn_cap, 1'b1, wn_r <= MAXC + CW'(1), "work count past its cap")
  `PTE_ASSERT_NXT(a_commit_count, ctl.commit && (wn_r <= MAXC), count_r == $past(wn_r),
                  "commit did not take the work count")

endmodule

`default_nettype wire

>>> hdl/piece_table_engine.sv
// piece table engine top level: sequencer plus datapath
// depends on pte_pkg, pte_ctrl, pte_datapath and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// A command is taken when start is high and busy is low; busy stays high
// until the last result has been issued. Clear, load and commands that are
// rejected up front go from the check state straight to done. Insert and
// erase walk the piece table in one memory bank, fetching each stored piece
// and pushing up to three pieces, writing the new table into the other bank,
// then flush, commit and report. A read walks the same way and stops at the
// last overlapped piece, giving one result per overlapped piece.
// Results appear for exactly one cycle with out_valid and cannot be held
// off, so the receiver must take every transfer as it comes. No clearing
// pass is needed after reset.
module piece_table_engine import pte_pkg::*; #(
  parameter int MAX_PIECES  = 64,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire pte_in_t in_data,
  output logic         out_valid,
  output pte_out_t     out_data
);

  pte_ctl_t ctl;
  pte_sts_t sts;

  // sequencer
  pte_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // table and result datapath
  pte_datapath #(
    .MAX_PIECES  (MAX_PIECES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `PTE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command did not go busy")
  `PTE_ASSERT_IMP(a_last_idle, out_valid && out_data.last, !busy,
                  "final transfer while still busy")
  `PTE_ASSERT_IMP(a_mid_busy, out_valid && !out_data.last, busy,
                  "non-final transfer after going idle")

endmodule

`default_nettype wire

>>> bench/tb_piece_table_engine.sv
// testbench for the piece table engine: drives commands, predicts every result
// depends on pte_pkg and piece_table_engine
`timescale 1ns / 1ps

module tb_piece_table_engine import pte_pkg::*; ();

  localparam int NPIECE = 64;
  localparam longint OFFMAX = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  pte_in_t in_data;
  logic out_valid;
  pte_out_t out_data;

  piece_table_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // predicted table state
  logic        tbl_src[NPIECE];
  logic [31:0] tbl_start[NPIECE];
  logic [31:0] tbl_len[NPIECE];
  int          tbl_cnt;
  logic [31:0] add_fill;

  // scratch table used while rebuilding
  logic        new_src[NPIECE+2];
  logic [31:0] new_start[NPIECE+2];
  logic [31:0] new_len[NPIECE+2];
  int          new_cnt;

  pte_out_t segs_due[$];
  int       fail_count;
  int       results_seen;
  int       items_sent;
  longint   cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run-away guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic longint doc_len();
    longint t;
    t = 0;
    for (int i = 0; i < tbl_cnt; i++) t = (t + tbl_len[i]) & OFFMAX;
    return t;
  endfunction

  // append to the scratch table, merging with a contiguous tail
  function automatic void push_piece(logic s, longint st, longint ln);
    int k;
    if (new_cnt > 0) begin
      k = new_cnt - 1;
      if (new_src[k] == s && ((longint'(new_start[k]) + new_len[k]) & OFFMAX) == st) begin
        new_len[k] = new_len[k] + ln[31:0];
        return;
      end
    end
    if (new_cnt < NPIECE + 2) begin
      new_src[new_cnt] = s;
      new_start[new_cnt] = st[31:0];
      new_len[new_cnt] = ln[31:0];
      new_cnt++;
    end
  endfunction

  function automatic bit commit_pieces();
    if (new_cnt > NPIECE) return 1'b0;
    for (int i = 0; i < new_cnt; i++) begin
      tbl_src[i] = new_src[i];
      tbl_start[i] = new_start[i];
      tbl_len[i] = new_len[i];
    end
    tbl_cnt = new_cnt;
    return 1'b1;
  endfunction

  function automatic pte_out_t make_seg(logic s, longint st, longint ln, logic lst,
                                        logic [1:0] stat);
    pte_out_t r;
    r.seg_source = s;
    r.seg_start = st[31:0];
    r.seg_length = ln[31:0];
    r.last = lst;
    r.status = stat;
    r.doc_size = doc_len();
    r.used_pieces = 7'(tbl_cnt);
    return r;
  endfunction

  // add one predicted result at the end of the expected list
  function automatic void queue_result(pte_out_t r);
    segs_due.insert(segs_due.size(), r);
  endfunction

  // apply one command to the predicted state and queue its results
  function automatic void predict_command(pte_in_t c);
    longint pos, cnt, sz, cur, loc, ln, stop, ps, pe, rs, ls, le;
    logic [1:0] stat;
    bit placed;
    int nres;
    pos = c.position;
    cnt = c.count;
    sz = doc_len();
    cur = 0;
    stat = STAT_NOP;
    nres = 0;
    case (c.cmd)
      CMD_CLEAR, CMD_LOAD_ADD, CMD_LOAD_ORIG: begin
        tbl_cnt = 0;
        add_fill = '0;
        if (cnt > 0 && c.cmd != CMD_CLEAR) begin
          tbl_src[0] = (c.cmd == CMD_LOAD_ADD);
          tbl_start[0] = '0;
          tbl_len[0] = cnt[31:0];
          tbl_cnt = 1;
          if (c.cmd == CMD_LOAD_ADD) add_fill = cnt[31:0];
        end
        stat = STAT_DONE;
      end
      CMD_INSERT: begin
        if (cnt == 0) stat = STAT_NOP;
        else if (cnt > OFFMAX - add_fill || cnt > OFFMAX - sz) stat = STAT_OVF;
        else begin
          placed = 1'b0;
          if (pos > sz) pos = sz;
          new_cnt = 0;
          for (int i = 0; i < tbl_cnt; i++) begin
            ln = tbl_len[i];
            if (!placed && pos <= cur + ln) begin
              loc = pos - cur;
              if (loc > 0) push_piece(tbl_src[i], tbl_start[i], loc);
              push_piece(1'b1, add_fill, cnt);
              if (loc < ln)
                push_piece(tbl_src[i], (tbl_start[i] + loc) & OFFMAX, ln - loc);
              placed = 1'b1;
            end else push_piece(tbl_src[i], tbl_start[i], ln);
            cur = cur + ln;
          end
          if (!placed) push_piece(1'b1, add_fill, cnt);
          if (commit_pieces()) begin
            add_fill = add_fill + cnt[31:0];
            stat = STAT_DONE;
          end else stat = STAT_FULL;
        end
      end
      CMD_ERASE: begin
        if (cnt == 0 || pos >= sz) stat = STAT_NOP;
        else begin
          stop = (cnt > sz - pos) ? sz : pos + cnt;
          new_cnt = 0;
          for (int i = 0; i < tbl_cnt; i++) begin
            ps = cur;
            pe = cur + tbl_len[i];
            cur = pe;
            if (pe <= pos || ps >= stop) push_piece(tbl_src[i], tbl_start[i], tbl_len[i]);
            else begin
              if (pos > ps) push_piece(tbl_src[i], tbl_start[i], pos - ps);
              rs = (ps > stop) ? ps : stop;
              if (rs < pe)
                push_piece(tbl_src[i], (tbl_start[i] + (rs - ps)) & OFFMAX, pe - rs);
            end
          end
          stat = commit_pieces() ? STAT_DONE : STAT_FULL;
        end
      end
      CMD_READ: begin
        if (cnt > 0 && pos < sz) begin
          stop = (cnt > sz - pos) ? sz : pos + cnt;
          for (int i = 0; i < tbl_cnt; i++) begin
            ps = cur;
            pe = cur + tbl_len[i];
            cur = pe;
            if (!(pe <= pos || ps >= stop)) begin
              ls = ((pos > ps) ? pos : ps) - ps;
              le = ((stop < pe) ? stop : pe) - ps;
              queue_result(make_seg(tbl_src[i], (tbl_start[i] + ls) & OFFMAX,
                                    le - ls, 1'b0, STAT_DONE));
              nres++;
            end
          end
          if (nres > 0) segs_due[$].last = 1'b1;
        end
        stat = STAT_NOP;
      end
      default: stat = STAT_NOP;
    endcase
    if (nres == 0) queue_result(make_seg(1'b0, 0, 0, 1'b1, stat));
  endfunction

  // result checker
  always @(posedge clk) begin
    pte_out_t exp_seg;
    if (rst_n && out_valid) begin
      results_seen++;
      if (segs_due.size() == 0) begin
        $error("unexpected result transfer %p", out_data);
        fail_count++;
      end else begin
        exp_seg = segs_due.pop_front();
        if (out_data.seg_source !== exp_seg.seg_source) begin
          $error("seg_source exp %0d got %0d", exp_seg.seg_source, out_data.seg_source);
          fail_count++;
        end
        if (out_data.seg_start !== exp_seg.seg_start) begin
          $error("seg_start exp %0d got %0d", exp_seg.seg_start, out_data.seg_start);
          fail_count++;
        end
        if (out_data.seg_length !== exp_seg.seg_length) begin
          $error("seg_length exp %0d got %0d", exp_seg.seg_length, out_data.seg_length);
          fail_count++;
        end
        if (out_data.last !== exp_seg.last) begin
          $error("last exp %0d got %0d", exp_seg.last, out_data.last);
          fail_count++;
        end
        if (out_data.status !== exp_seg.status) begin
          $error("status exp %0d got %0d", exp_seg.status, out_data.status);
          fail_count++;
        end
        if (out_data.doc_size !== exp_seg.doc_size) begin
          $error("doc_size exp %0d got %0d", exp_seg.doc_size, out_data.doc_size);
          fail_count++;
        end
        if (out_data.used_pieces !== exp_seg.used_pieces) begin
          $error("used_pieces exp %0d got %0d", exp_seg.used_pieces, out_data.used_pieces);
          fail_count++;
        end
      end
    end
  end

  // random gap before a command, mostly short
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  // one command transfer, held until accepted
  task automatic send_command(logic [2:0] c, logic [31:0] p, logic [31:0] n);
    pte_in_t item;
    item.cmd = c;
    item.position = p;
    item.count = n;
    idle_gap();
    in_data = item;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_command(item);
    items_sent++;
    @(negedge clk);
    start = 1'b0;
    in_data = {3'($urandom), $urandom, $urandom};
  endtask

  task automatic drain_results();
    while (segs_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_span();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($urandom_range(0, 3));
      default: return 32'($urandom_range(1, 60));
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    longint sz;
    sz = doc_len();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 32'(sz + 2)));
  endfunction

  // clears, loads, extremes of the fields and unused codes
  task automatic test_directed();
    send_command(CMD_READ, 0, 5);
    send_command(CMD_ERASE, 0, 5);
    send_command(CMD_INSERT, 0, 0);
    send_command(CMD_INSERT, 32'hFFFF_FFFF, 10);
    send_command(CMD_INSERT, 3, 4);
    send_command(CMD_INSERT, 10, 5);
    send_command(CMD_READ, 0, 32'hFFFF_FFFF);
    send_command(CMD_LOAD_ORIG, 32'hFFFF_FFFF, 100);
    send_command(CMD_INSERT, 50, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 50, 7);
    send_command(CMD_ERASE, 48, 4);
    send_command(CMD_ERASE, 0, 32'hFFFF_FFFF);
    send_command(CMD_LOAD_ADD, 0, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 5, 1);
    send_command(CMD_READ, 32'hFFFF_FFFE, 2);
    send_command(CMD_LOAD_ADD, 0, 0);
    send_command(CMD_LOAD_ORIG, 0, 32'h8000_0000);
    send_command(CMD_READ, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_command(3'd6, 0, 0);
    send_command(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();
  endtask

  // fragment the table until it fills, then erase and read across it
  task automatic test_table_full();
    send_command(CMD_LOAD_ORIG, 0, 2000);
    for (int i = 0; i < 40; i++) send_command(CMD_INSERT, 32'(i * 45), 1);
    send_command(CMD_ERASE, 100, 3);
    send_command(CMD_READ, 0, 32'hFFFF_FFFF);
    send_command(CMD_ERASE, 30, 900);
    send_command(CMD_READ, 0, 2000);
  endtask

  // mostly edits on a loaded document, some noise and odd codes
  task automatic test_random_edits(int n);
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: c = CMD_CLEAR;
        1: c = CMD_LOAD_ADD;
        2: c = CMD_LOAD_ORIG;
        3: c = 3'($urandom_range(6, 7));
        4, 5, 6, 7, 8, 9: c = CMD_INSERT;
        10, 11, 12, 13: c = CMD_ERASE;
        default: c = CMD_READ;
      endcase
      if (c == CMD_LOAD_ADD || c == CMD_LOAD_ORIG)
        send_command(c, $urandom, ($urandom_range(0, 7) == 0) ? $urandom
                                                               : 32'($urandom_range(0, 300)));
      else send_command(c, rand_pos(), rand_span());
      // hold off now and then until the engine has answered everything
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    items_sent = 0;
    tbl_cnt = 0;
    add_fill = '0;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    drain_results();
    test_random_edits(400);
    drain_results();

    $display("sent %0d commands, checked %0d result transfers", items_sent, results_seen);
    $display("covered loads, clamped inserts, splits, merges, full table and overflow");
    if (fail_count == 0 && segs_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
